// ===== rtl/grst_pkg.sv =====
// ----------------------------------------------------------------------------
// grst_pkg: shared types and constants of the 3D grid restriction block
// Register map, opcodes, arithmetic widths, sequencer states and tap weights.
// ----------------------------------------------------------------------------
package grst_pkg;

  // Field widths
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int VAL_W   = 24;
  localparam int WGT_W   = 4;
  localparam int WPROD_W = 10;
  // Weights are integers over 512; 64 taps of 24-bit samples fit in 35 bits
  localparam int ACC_W   = 35;
  localparam int WGT_SHIFT = 9;
  localparam int ROUND_BIAS = 256;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_FINE_X   = 3'd0;
  localparam logic [2:0] REG_FINE_Y   = 3'd1;
  localparam logic [2:0] REG_FINE_Z   = 3'd2;
  localparam logic [2:0] REG_COARSE_X = 3'd3;
  localparam logic [2:0] REG_COARSE_Y = 3'd4;
  localparam logic [2:0] REG_COARSE_Z = 3'd5;

  localparam logic [SIZE_W-1:0] FINE_RST   = 6'd32;
  localparam logic [SIZE_W-1:0] COARSE_RST = 6'd16;

  // Item kinds
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Kernel weights over 8
  localparam logic [WGT_W-1:0] W_OUTER  = 4'd1;
  localparam logic [WGT_W-1:0] W_INNER  = 4'd3;
  localparam logic [WGT_W-1:0] W_INJECT = 4'd8;

  localparam logic [1:0] TAP_FIRST = 2'd0;
  localparam logic [1:0] TAP_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Weight of one axis tap: outer taps 1, inner taps 3, injection 8
  function automatic logic [WGT_W-1:0] tap_weight(input logic full, input logic [1:0] tap);
    logic [WGT_W-1:0] w;
    if (!full) begin
      w = W_INJECT;
    end else if (tap == TAP_FIRST || tap == TAP_LAST) begin
      w = W_OUTER;
    end else begin
      w = W_INNER;
    end
    return w;
  endfunction

endpackage

// ===== rtl/grst_axis.sv =====
// ----------------------------------------------------------------------------
// grst_axis: tap generator of one axis
// Picks full weighting or injection and returns the four clamped fine indices.
// ----------------------------------------------------------------------------
module grst_axis #(
  parameter int DIM_MAX = 32
) (
  input  logic [grst_pkg::COORD_W-1:0] coord_i,
  input  logic [grst_pkg::SIZE_W-1:0]  fine_i,
  input  logic [grst_pkg::SIZE_W-1:0]  coarse_i,
  output logic                         full_o,
  output logic [3:0][$clog2(DIM_MAX)-1:0] idx_o
);

  localparam int IW = $clog2(DIM_MAX);
  localparam int CW = ($clog2(DIM_MAX + 1) > 7) ? $clog2(DIM_MAX + 1) : 7;

  logic [CW-1:0]      base;
  logic [CW-1:0]      lim;
  logic [3:0][CW-1:0] raw;
  logic [CW-1:0]      clamped;
  logic [grst_pkg::SIZE_W-1:0] next_c;

  // Full weighting when fine size is exactly twice the coarse size
  assign full_o = ({1'b0, fine_i} == {coarse_i, 1'b0});
  assign base   = CW'({coord_i, 1'b0});
  assign next_c = {1'b0, coord_i} + grst_pkg::SIZE_W'(1);

  // Raw taps; fold the outer taps back at both grid ends
  always_comb begin
    raw[1] = base;
    raw[2] = base + CW'(1);
    if (full_o && coord_i != '0) begin
      raw[0] = base - CW'(1);
    end else begin
      raw[0] = base;
    end
    if (!full_o) begin
      raw[3] = base;
    end else if (next_c < coarse_i) begin
      raw[3] = base + CW'(2);
    end else begin
      raw[3] = base + CW'(1);
    end
  end

  // Clamp every tap to min(fine size, DIM_MAX) - 1
  assign lim = (CW'(fine_i) < CW'(DIM_MAX)) ? CW'(fine_i) : CW'(DIM_MAX);

  always_comb begin
    clamped = '0;
    for (int t = 0; t < 4; t++) begin
      if (lim == '0) begin
        clamped = '0;
      end else if (raw[t] >= lim) begin
        clamped = lim - CW'(1);
      end else begin
        clamped = raw[t];
      end
      idx_o[t] = clamped[IW-1:0];
    end
  end

endmodule

// ===== rtl/grid_restriction_3d.sv =====
// ----------------------------------------------------------------------------
// grid_restriction_3d: full-weighting restriction of a fine 3D grid
// Loads fine samples into an on-chip memory and restricts single coarse cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = operation. A write word (operation 0) stores sample
//   at fine cell (coord_x, coord_y, coord_z) and gives no result;
//   writes outside the configured fine grid are dropped. A compute word
//   (operation 1) names a coarse cell and gives one master word: tdata is the
//   rounded, saturated Q11.12 value, tuser flags a bad coarse coordinate.
//   A compute reads one fine sample per cycle from the single memory read port,
//   1, 4, 16 or 64 taps depending on how many axes use full weighting; each
//   tap passes the read, product and accumulator registers before the output
//   register loads, and a bad coordinate skips the reads. One item at a time.
//   The output register decouples the sides: a new word is accepted while a
//   result waits; a finished compute holds until that register is free.
//   Reset: sizes return to fine 32 / coarse 16, the sequencer goes idle and
//   the output empties. Fine memory content is undefined until written.
//   The user must write configuration over APB only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module grid_restriction_3d #(
  parameter int DIM_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] coord_x, [9:5] coord_y, [14:10] coord_z, [38:15] sample, [39] zero
  input  logic [39:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] coarse_value
  output logic [23:0] m_axis_tdata,
  // [0] bad_coordinate
  output logic        m_axis_tuser,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [grst_pkg::CFG_AW-1:0] paddr,
  input  logic [grst_pkg::CFG_DW-1:0] pwdata,
  output logic [grst_pkg::CFG_DW-1:0] prdata,
  output logic        pready
);

  localparam int IW    = $clog2(DIM_MAX);
  localparam int CW    = ($clog2(DIM_MAX + 1) > 7) ? $clog2(DIM_MAX + 1) : 7;
  localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(DEPTH);

  localparam int SW  = grst_pkg::SIZE_W;
  localparam int VW  = grst_pkg::VAL_W;
  localparam int ACW = grst_pkg::ACC_W;

  localparam logic signed [ACW-1:0] VAL_MAX = ACW'(8388607);
  localparam logic signed [ACW-1:0] VAL_MIN = -ACW'(8388608);

  // --------------------------------------------------------------------------
  // Input word unpacking
  // --------------------------------------------------------------------------
  logic                           in_op;
  logic [grst_pkg::COORD_W-1:0]   in_x, in_y, in_z;
  logic signed [VW-1:0]           in_sample;
  logic                           in_acc;

  assign in_op     = s_axis_tuser;
  assign in_x      = s_axis_tdata[4:0];
  assign in_y      = s_axis_tdata[9:5];
  assign in_z      = s_axis_tdata[14:10];
  assign in_sample = s_axis_tdata[38:15];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0] fine_x_q, fine_y_q, fine_z_q;
  logic [SW-1:0] coarse_x_q, coarse_y_q, coarse_z_q;
  logic          cfg_we;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_x_q   <= grst_pkg::FINE_RST;
      fine_y_q   <= grst_pkg::FINE_RST;
      fine_z_q   <= grst_pkg::FINE_RST;
      coarse_x_q <= grst_pkg::COARSE_RST;
      coarse_y_q <= grst_pkg::COARSE_RST;
      coarse_z_q <= grst_pkg::COARSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        grst_pkg::REG_FINE_X:   fine_x_q   <= pwdata[SW-1:0];
        grst_pkg::REG_FINE_Y:   fine_y_q   <= pwdata[SW-1:0];
        grst_pkg::REG_FINE_Z:   fine_z_q   <= pwdata[SW-1:0];
        grst_pkg::REG_COARSE_X: coarse_x_q <= pwdata[SW-1:0];
        grst_pkg::REG_COARSE_Y: coarse_y_q <= pwdata[SW-1:0];
        grst_pkg::REG_COARSE_Z: coarse_z_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    unique case (cfg_idx)
      grst_pkg::REG_FINE_X:   prdata = grst_pkg::CFG_DW'(fine_x_q);
      grst_pkg::REG_FINE_Y:   prdata = grst_pkg::CFG_DW'(fine_y_q);
      grst_pkg::REG_FINE_Z:   prdata = grst_pkg::CFG_DW'(fine_z_q);
      grst_pkg::REG_COARSE_X: prdata = grst_pkg::CFG_DW'(coarse_x_q);
      grst_pkg::REG_COARSE_Y: prdata = grst_pkg::CFG_DW'(coarse_y_q);
      grst_pkg::REG_COARSE_Z: prdata = grst_pkg::CFG_DW'(coarse_z_q);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tap generation per axis
  // --------------------------------------------------------------------------
  logic                full_x, full_y, full_z;
  logic [3:0][IW-1:0]  idx_x, idx_y, idx_z;

  grst_axis #(.DIM_MAX(DIM_MAX)) u_axis_x (
    .coord_i (in_x), .fine_i (fine_x_q), .coarse_i (coarse_x_q),
    .full_o  (full_x), .idx_o (idx_x)
  );
  grst_axis #(.DIM_MAX(DIM_MAX)) u_axis_y (
    .coord_i (in_y), .fine_i (fine_y_q), .coarse_i (coarse_y_q),
    .full_o  (full_y), .idx_o (idx_y)
  );
  grst_axis #(.DIM_MAX(DIM_MAX)) u_axis_z (
    .coord_i (in_z), .fine_i (fine_z_q), .coarse_i (coarse_z_q),
    .full_o  (full_z), .idx_o (idx_z)
  );

  logic bad_coord;
  assign bad_coord = ({1'b0, in_x} >= coarse_x_q) || ({1'b0, in_y} >= coarse_y_q) ||
                     ({1'b0, in_z} >= coarse_z_q);

  // Write lands only inside the fine grid and inside the memory
  logic wr_ok;
  assign wr_ok = ({1'b0, in_x} < fine_x_q) && ({1'b0, in_y} < fine_y_q) &&
                 ({1'b0, in_z} < fine_z_q) && (CW'(in_x) < CW'(DIM_MAX)) &&
                 (CW'(in_y) < CW'(DIM_MAX)) && (CW'(in_z) < CW'(DIM_MAX));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  grst_pkg::state_e state_q, state_d;
  logic issue, load_out, start_run, start_bad, mem_we;
  logic last_a, last_b, last_c, last_all;
  logic v1_q, last1_q, v2_q, last2_q;
  logic out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grst_pkg::ST_IDLE: begin
        if (start_run) begin
          state_d = grst_pkg::ST_RUN;
        end else if (start_bad) begin
          state_d = grst_pkg::ST_FINISH;
        end
      end
      grst_pkg::ST_RUN: begin
        if (last_all) state_d = grst_pkg::ST_DRAIN;
      end
      grst_pkg::ST_DRAIN: begin
        if (v2_q && last2_q) state_d = grst_pkg::ST_FINISH;
      end
      grst_pkg::ST_FINISH: begin
        if (load_out) state_d = grst_pkg::ST_IDLE;
      end
      default: state_d = grst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == grst_pkg::ST_IDLE);
    issue         = (state_q == grst_pkg::ST_RUN);
    load_out      = (state_q == grst_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
    start_run     = in_acc && (in_op == grst_pkg::OP_COMPUTE) && !bad_coord;
    start_bad     = in_acc && (in_op == grst_pkg::OP_COMPUTE) && bad_coord;
    mem_we        = in_acc && (in_op == grst_pkg::OP_WRITE) && wr_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Tap registers and tap counters
  // --------------------------------------------------------------------------
  logic [3:0][IW-1:0] tx_q, ty_q, tz_q;
  logic               fx_q, fy_q, fz_q;
  logic               bad_q;
  logic [1:0]         ta_q, tb_q, tc_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_q <= idx_x;
      ty_q <= idx_y;
      tz_q <= idx_z;
      fx_q <= full_x;
      fy_q <= full_y;
      fz_q <= full_z;
    end
  end

  assign last_a   = !fx_q || (ta_q == grst_pkg::TAP_LAST);
  assign last_b   = !fy_q || (tb_q == grst_pkg::TAP_LAST);
  assign last_c   = !fz_q || (tc_q == grst_pkg::TAP_LAST);
  assign last_all = last_a && last_b && last_c;

  // Step x fastest, then y, then z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q  <= '0;
      tb_q  <= '0;
      tc_q  <= '0;
      bad_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ta_q  <= '0;
        tb_q  <= '0;
        tc_q  <= '0;
        bad_q <= bad_coord;
      end else if (issue) begin
        if (!last_a) begin
          ta_q <= ta_q + 2'd1;
        end else begin
          ta_q <= '0;
          if (!last_b) begin
            tb_q <= tb_q + 2'd1;
          end else begin
            tb_q <= '0;
            tc_q <= tc_q + 2'd1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Fine sample memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] mem [DEPTH];
  logic [AW-1:0]        wr_addr, rd_addr;
  logic signed [VW-1:0] rd_q;
  logic [IW-1:0]        rix, riy, riz;

  assign wr_addr = AW'(CW'(in_z)) * AW'(DIM_MAX * DIM_MAX) +
                   AW'(CW'(in_y)) * AW'(DIM_MAX) + AW'(CW'(in_x));
  assign rix     = tx_q[ta_q];
  assign riy     = ty_q[tb_q];
  assign riz     = tz_q[tc_q];
  assign rd_addr = AW'(riz) * AW'(DIM_MAX * DIM_MAX) + AW'(riy) * AW'(DIM_MAX) + AW'(rix);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= in_sample;
    if (issue)  rd_q <= mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Weight, multiply and accumulate pipeline
  // --------------------------------------------------------------------------
  logic [grst_pkg::WPROD_W-1:0] wprod, w1_q;
  logic signed [ACW-1:0]        prod_q, acc_q;

  assign wprod = grst_pkg::WPROD_W'(grst_pkg::tap_weight(fx_q, ta_q)) *
                 grst_pkg::WPROD_W'(grst_pkg::tap_weight(fy_q, tb_q)) *
                 grst_pkg::WPROD_W'(grst_pkg::tap_weight(fz_q, tc_q));

  always_ff @(posedge clk_i) begin
    if (issue) w1_q <= wprod;
    if (v1_q)  prod_q <= ACW'(rd_q) * ACW'($signed({1'b0, w1_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= issue;
      last1_q <= issue && last_all;
      v2_q    <= v1_q;
      last2_q <= v1_q && last1_q;
      if (in_acc) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Round to nearest (ties up), saturate, and hold the result word
  // --------------------------------------------------------------------------
  logic signed [ACW-1:0] rnd, shr;
  logic [VW-1:0]         res;
  logic [VW-1:0]         out_data_q;
  logic                  out_bad_q;

  always_comb begin
    rnd = acc_q + ACW'(grst_pkg::ROUND_BIAS);
    shr = rnd >>> grst_pkg::WGT_SHIFT;
    priority if (bad_q) begin
      res = '0;
    end else if (shr > VAL_MAX) begin
      res = VAL_MAX[VW-1:0];
    end else if (shr < VAL_MIN) begin
      res = VAL_MIN[VW-1:0];
    end else begin
      res = shr[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= res;
      out_bad_q  <= bad_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_bad_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Pipeline is empty whenever the sequencer is idle or finishing
  a_pipe_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grst_pkg::ST_IDLE || state_q == grst_pkg::ST_FINISH) |-> !v1_q && !v2_q)
    else $error("read pipeline busy outside a compute");

  // A bad coordinate never starts memory reads
  a_bad_no_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !bad_q)
    else $error("memory read issued for a bad coordinate");

  // The last tap leaves the run state in the next cycle
  a_last_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_all) |=> (state_q == grst_pkg::ST_DRAIN) && last1_q)
    else $error("sequencer missed the last tap");

  // A loaded result is presented in the next cycle
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid && (m_axis_tuser == $past(bad_q)))
    else $error("result word not presented after load");

endmodule

// ===== test/grid_restriction_3d_tb.sv =====
// ----------------------------------------------------------------------------
// grid_restriction_3d_tb: self-checking bench of the 3D grid restriction block
// Streams fine sample writes and coarse cell requests under a series of grid
// sizes. Each accepted word updates a shadow copy of the fine grid or predicts
// one restricted value, and the master side is checked against that in order.
// Requests only ever touch fine cells that were written earlier.
// ----------------------------------------------------------------------------
module grid_restriction_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX        = 32;
  localparam int GRID_DEPTH     = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 155;
  localparam int HOLD_PHASE     = 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;
  localparam logic [grst_pkg::VAL_W-1:0] VAL_POS_MAX = 24'h7FFFFF;
  localparam logic [grst_pkg::VAL_W-1:0] VAL_NEG_MAX = 24'h800000;

  // One slave word: [4:0] x, [9:5] y, [14:10] z, [38:15] sample; op travels in tuser
  typedef struct packed {
    logic                         op;
    logic [grst_pkg::VAL_W-1:0]   sample;
    logic [grst_pkg::COORD_W-1:0] z;
    logic [grst_pkg::COORD_W-1:0] y;
    logic [grst_pkg::COORD_W-1:0] x;
  } grid_word_t;

  typedef struct packed {
    logic [grst_pkg::VAL_W-1:0] value;
    logic                       bad;
  } coarse_t;

  // Fine taps of one axis: count, clamped indices and weights over 8
  typedef struct packed {
    logic [2:0]                            n;
    logic [3:0][grst_pkg::COORD_W-1:0]     idx;
    logic [3:0][grst_pkg::WGT_W-1:0]       wt;
  } axis_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [39:0]                   s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [grst_pkg::CFG_AW-1:0]   paddr = '0;
  logic [grst_pkg::CFG_DW-1:0]   pwdata = '0;
  logic [grst_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;

  // Sizes as the block holds them, shared by the generator and the predictor
  int fine_sz [3]   = '{32, 32, 32};
  int coarse_sz [3] = '{16, 16, 16};

  logic signed [grst_pkg::VAL_W-1:0] fine_shadow [GRID_DEPTH];
  bit                                gen_written [GRID_DEPTH];

  grid_word_t word_q [$];
  coarse_t    coarse_q [$];

  int  phase_cfg [N_PHASES][6] = '{
    '{4, 4, 4, 2, 2, 2},
    '{8, 5, 32, 4, 3, 32},
    '{1, 1, 1, 1, 1, 1},
    '{2, 32, 6, 1, 16, 3},
    '{32, 32, 32, 32, 32, 32},
    '{16, 2, 3, 8, 1, 4},
    '{32, 32, 32, 16, 16, 16}
  };

  int  n_pushed = 0, n_useful = 0, n_accepted = 0;
  int  n_writes = 0, n_dropped = 0, n_requests = 0, n_flagged = 0;
  int  n_checked = 0, n_errors = 0, n_settings = 0;
  int  hold_req = 0, hold_seen = 0, hold_left = 0;
  int  gap_left = 0, stall_left = 0, idle_cycles = 0;
  bit  quiet = 1'b0;

  grid_restriction_3d #(
    .DIM_MAX(DIM_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int cell_addr(input int x, input int y, input int z);
    return (z * DIM_MAX + y) * DIM_MAX + x;
  endfunction

  function automatic bit in_fine_grid(input int x, input int y, input int z);
    return x < fine_sz[0] && y < fine_sz[1] && z < fine_sz[2];
  endfunction

  // Full weighting when fine is exactly twice coarse, else inject at 2c
  function automatic axis_t axis_taps(input int c, input int fine, input int coarse);
    axis_t a;
    int    raw [4];
    int    lim;
    a = '0;
    if (fine == 2 * coarse) begin
      raw[0] = (c > 0) ? 2 * c - 1 : 2 * c;
      raw[1] = 2 * c;
      raw[2] = 2 * c + 1;
      raw[3] = (c + 1 < coarse) ? 2 * c + 2 : 2 * c + 1;
      a.n = 3'd4;
      a.wt[0] = grst_pkg::W_OUTER;
      a.wt[1] = grst_pkg::W_INNER;
      a.wt[2] = grst_pkg::W_INNER;
      a.wt[3] = grst_pkg::W_OUTER;
    end else begin
      raw[0] = 2 * c;
      raw[1] = 0;
      raw[2] = 0;
      raw[3] = 0;
      a.n = 3'd1;
      a.wt[0] = grst_pkg::W_INJECT;
    end
    // Clamp every index into the fine grid
    lim = (fine < DIM_MAX) ? fine : DIM_MAX;
    for (int t = 0; t < 4; t++) begin
      if (lim == 0) begin
        raw[t] = 0;
      end else if (raw[t] >= lim) begin
        raw[t] = lim - 1;
      end
      a.idx[t] = grst_pkg::COORD_W'(raw[t]);
    end
    return a;
  endfunction

  // Weighted sum over 512, rounded half up, saturated to Q11.12
  function automatic coarse_t restrict_cell(input grid_word_t w);
    coarse_t r;
    axis_t   ax, ay, az;
    longint  acc, q;
    int      wgt;
    r = '0;
    if (int'(w.x) >= coarse_sz[0] || int'(w.y) >= coarse_sz[1] ||
        int'(w.z) >= coarse_sz[2]) begin
      r.bad = 1'b1;
      return r;
    end
    ax = axis_taps(int'(w.x), fine_sz[0], coarse_sz[0]);
    ay = axis_taps(int'(w.y), fine_sz[1], coarse_sz[1]);
    az = axis_taps(int'(w.z), fine_sz[2], coarse_sz[2]);
    acc = 0;
    for (int k = 0; k < az.n; k++) begin
      for (int b = 0; b < ay.n; b++) begin
        for (int a = 0; a < ax.n; a++) begin
          wgt = int'(ax.wt[a]) * int'(ay.wt[b]) * int'(az.wt[k]);
          acc += longint'(wgt) *
                 longint'(fine_shadow[cell_addr(ax.idx[a], ay.idx[b], az.idx[k])]);
        end
      end
    end
    q = (acc + grst_pkg::ROUND_BIAS) >>> grst_pkg::WGT_SHIFT;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    r.value = q[grst_pkg::VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [grst_pkg::VAL_W-1:0] rand_sample();
    logic [grst_pkg::VAL_W-1:0] s;
    case ($urandom_range(7, 0))
      0:       s = VAL_POS_MAX;
      1:       s = VAL_NEG_MAX;
      2:       s = '0;
      3:       s = '1;
      default: s = grst_pkg::VAL_W'($urandom);
    endcase
    return s;
  endfunction

  // Favor the corners, where the taps fold back
  function automatic int pick_coarse(input int cs);
    int c;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: c = $urandom_range((cs > 3) ? 2 : cs - 1, 0);
      5, 6, 7:       c = $urandom_range(cs - 1, (cs > 3) ? cs - 3 : 0);
      default:       c = $urandom_range(cs - 1, 0);
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [grst_pkg::VAL_W-1:0] got,
                                 input logic [grst_pkg::VAL_W-1:0] want);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch on result %0d: %s got %h want %h",
               $realtime, n_checked, what, got, want);
    end
  endtask

  task automatic push_word(input logic op, input int x, input int y, input int z,
                           input logic [grst_pkg::VAL_W-1:0] s);
    grid_word_t w;
    w.op     = op;
    w.x      = grst_pkg::COORD_W'(x);
    w.y      = grst_pkg::COORD_W'(y);
    w.z      = grst_pkg::COORD_W'(z);
    w.sample = s;
    word_q   = {word_q, w};
    n_pushed++;
    if (op == grst_pkg::OP_COMPUTE) begin
      n_useful++;
    end else if (in_fine_grid(x, y, z)) begin
      n_useful++;
      gen_written[cell_addr(x, y, z)] = 1'b1;
    end
  endtask

  // Write any tap cell not yet loaded, then ask for the coarse cell
  task automatic request_cell(input int cx, input int cy, input int cz);
    axis_t ax, ay, az;
    ax = axis_taps(cx, fine_sz[0], coarse_sz[0]);
    ay = axis_taps(cy, fine_sz[1], coarse_sz[1]);
    az = axis_taps(cz, fine_sz[2], coarse_sz[2]);
    for (int k = 0; k < az.n; k++) begin
      for (int b = 0; b < ay.n; b++) begin
        for (int a = 0; a < ax.n; a++) begin
          if (!gen_written[cell_addr(ax.idx[a], ay.idx[b], az.idx[k])]) begin
            push_word(grst_pkg::OP_WRITE, ax.idx[a], ay.idx[b], az.idx[k], rand_sample());
          end
        end
      end
    end
    push_word(grst_pkg::OP_COMPUTE, cx, cy, cz, grst_pkg::VAL_W'($urandom));
  endtask

  task automatic gen_random_word();
    int  pick, ax;
    int  c [3];
    bit  fine_short, coarse_short;
    fine_short   = fine_sz[0] < DIM_MAX || fine_sz[1] < DIM_MAX || fine_sz[2] < DIM_MAX;
    coarse_short = coarse_sz[0] < DIM_MAX || coarse_sz[1] < DIM_MAX ||
                   coarse_sz[2] < DIM_MAX;
    pick = $urandom_range(99, 0);
    if (pick < 8 && fine_short) begin
      // Write past the fine grid on one axis; the block drops it
      do ax = $urandom_range(2, 0); while (fine_sz[ax] >= DIM_MAX);
      for (int k = 0; k < 3; k++) c[k] = $urandom_range(31, 0);
      c[ax] = $urandom_range(31, fine_sz[ax]);
      push_word(grst_pkg::OP_WRITE, c[0], c[1], c[2], rand_sample());
    end else if (pick < 45) begin
      for (int k = 0; k < 3; k++) c[k] = $urandom_range(fine_sz[k] - 1, 0);
      push_word(grst_pkg::OP_WRITE, c[0], c[1], c[2], rand_sample());
    end else if (pick < 53 && coarse_short) begin
      do ax = $urandom_range(2, 0); while (coarse_sz[ax] >= DIM_MAX);
      for (int k = 0; k < 3; k++) c[k] = $urandom_range(31, 0);
      c[ax] = $urandom_range(31, coarse_sz[ax]);
      push_word(grst_pkg::OP_COMPUTE, c[0], c[1], c[2], grst_pkg::VAL_W'($urandom));
    end else begin
      for (int k = 0; k < 3; k++) c[k] = pick_coarse(coarse_sz[k]);
      request_cell(c[0], c[1], c[2]);
    end
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_size(input logic [2:0] reg_idx, input int size);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= grst_pkg::CFG_DW'(size);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      grst_pkg::REG_FINE_X:   fine_sz[0] = size;
      grst_pkg::REG_FINE_Y:   fine_sz[1] = size;
      grst_pkg::REG_FINE_Z:   fine_sz[2] = size;
      grst_pkg::REG_COARSE_X: coarse_sz[0] = size;
      grst_pkg::REG_COARSE_Y: coarse_sz[1] = size;
      grst_pkg::REG_COARSE_Z: coarse_sz[2] = size;
      default: ;
    endcase
  endtask

  task automatic write_grid_sizes(input int fx, input int fy, input int fz,
                                  input int cx, input int cy, input int cz);
    write_size(grst_pkg::REG_FINE_X, fx);
    write_size(grst_pkg::REG_FINE_Y, fy);
    write_size(grst_pkg::REG_FINE_Z, fz);
    write_size(grst_pkg::REG_COARSE_X, cx);
    write_size(grst_pkg::REG_COARSE_Y, cy);
    write_size(grst_pkg::REG_COARSE_Z, cz);
    n_settings++;
  endtask

  // Hold until every word is taken and every result is back
  task automatic wait_results();
    do @(posedge clk_i); while (n_accepted != n_pushed || coarse_q.size() != 0);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Slave side driver: offer queued words with random gaps
  always @(posedge clk_i) begin : drv
    grid_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && word_q.size() != 0 && $urandom_range(7, 0) == 0) begin
        gap_left = $urandom_range(5, 0);
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.sample, w.z, w.y, w.x};
        s_axis_tuser  <= w.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Master side ready: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin : rx
    logic rdy;
    rdy = 1'b1;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(7, 0) == 0) begin
      stall_left = $urandom_range(5, 0);
      rdy = 1'b0;
    end
    m_axis_tready <= rdy && rst_ni;
  end

  // Track accepted words and check results in order
  always @(posedge clk_i) begin : mon
    grid_word_t w;
    coarse_t    e;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      w.x      = s_axis_tdata[4:0];
      w.y      = s_axis_tdata[9:5];
      w.z      = s_axis_tdata[14:10];
      w.sample = s_axis_tdata[38:15];
      w.op     = s_axis_tuser;
      if (w.op == grst_pkg::OP_WRITE) begin
        if (in_fine_grid(w.x, w.y, w.z)) begin
          fine_shadow[cell_addr(w.x, w.y, w.z)] = w.sample;
          n_writes++;
        end else begin
          n_dropped++;
        end
      end else begin
        e = restrict_cell(w);
        coarse_q = {coarse_q, e};
        n_requests++;
        if (e.bad) n_flagged++;
      end
      n_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (coarse_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        e = coarse_q.pop_front();
        if (m_axis_tdata !== e.value) report_mismatch("coarse_value", m_axis_tdata, e.value);
        if (m_axis_tuser !== e.bad) begin
          report_mismatch("bad_coordinate", grst_pkg::VAL_W'(m_axis_tuser),
                          grst_pkg::VAL_W'(e.bad));
        end
      end
      n_checked++;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d words queued, %0d results owed",
               idle_cycles, word_q.size(), coarse_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stim
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: coarse cells at and past 16 are flagged
    push_word(grst_pkg::OP_COMPUTE, 16, 0, 0, '0);
    push_word(grst_pkg::OP_COMPUTE, 0, 31, 0, '0);
    push_word(grst_pkg::OP_COMPUTE, 15, 15, 16, '0);
    wait_idle();

    // Smallest full-weighting grid: both end taps fold on each axis
    write_grid_sizes(2, 2, 2, 1, 1, 1);
    for (int k = 0; k < 8; k++) push_word(grst_pkg::OP_WRITE, k[0], k[1], k[2], VAL_POS_MAX);
    push_word(grst_pkg::OP_COMPUTE, 0, 0, 0, '0);
    for (int k = 0; k < 8; k++) push_word(grst_pkg::OP_WRITE, k[0], k[1], k[2], VAL_NEG_MAX);
    push_word(grst_pkg::OP_COMPUTE, 0, 0, 0, '1);
    push_word(grst_pkg::OP_WRITE, 2, 0, 0, VAL_POS_MAX);
    push_word(grst_pkg::OP_WRITE, 31, 31, 31, '1);
    push_word(grst_pkg::OP_COMPUTE, 1, 0, 0, '0);
    wait_idle();

    // Random phases, each under its own sizes
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) quiet = 1'b1;
      write_grid_sizes(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                       phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5]);
      target = n_useful + PHASE_ITEMS / 2;
      while (n_useful < target) gen_random_word();
      if (p == HOLD_PHASE) hold_req++;
      // Sender pause: let every result come back mid-phase
      wait_results();
      target = n_useful + PHASE_ITEMS - PHASE_ITEMS / 2;
      while (n_useful < target) gen_random_word();
      wait_idle();
    end

    $display("covered %0d sample writes (%0d off-grid dropped), %0d cell requests (%0d flagged)",
             n_writes, n_dropped, n_requests, n_flagged);
    $display("checked %0d results across %0d grid size settings", n_checked, n_settings);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== grid_restriction_3d.f =====
rtl/grst_pkg.sv
rtl/grst_axis.sv
rtl/grid_restriction_3d.sv
test/grid_restriction_3d_tb.sv
